/* design/qrs_pkg.sv */
// Package for the quadratic real root solver: widths, codes and the
// structs that travel alongside the pipelined square root and divider.
// No dependencies.
package qrs_pkg;

  localparam int FRAC_BITS = 16;
  localparam int FIELD_W   = 32;
  localparam int MAG_W     = 32;
  localparam int PROD_W    = 2 * MAG_W;
  localparam int DISC_W    = PROD_W + 2;
  localparam int ROOT_W    = DISC_W / 2;
  localparam int SQ_STAGES = ROOT_W;
  localparam int NUM_W     = ROOT_W + 1;
  localparam int DIVD_W    = NUM_W + FRAC_BITS;
  localparam int DEN_W     = MAG_W + 1;
  localparam int DV_STAGES = DIVD_W;

  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_LEAD_ZERO = 2'd1;
  localparam logic [1:0] STAT_SAT       = 2'd2;

  localparam logic [1:0] CNT_NONE   = 2'd0;
  localparam logic [1:0] CNT_SINGLE = 2'd1;
  localparam logic [1:0] CNT_PAIR   = 2'd2;

  // carried alongside the square root
  typedef struct packed {
    logic             a_zero;
    logic             d_neg;
    logic             d_zero;
    logic             an;
    logic             nb;
    logic [MAG_W-1:0] ub;
    logic [DEN_W-1:0] den;
  } sq_side_t;

  // carried alongside the dividers
  typedef struct packed {
    logic [1:0] count;
    logic       lead_zero;
    logic       neg1;
    logic       neg2;
  } post_t;

endpackage

/* design/qrs_if.sv */
// Channel interfaces for the quadratic real root solver: coefficient
// input and root result. Depends on qrs_pkg.
interface qrs_in_if import qrs_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [FIELD_W-1:0] coef_square;
  logic [FIELD_W-1:0] coef_linear;
  logic [FIELD_W-1:0] coef_constant;
  modport source (output valid, coef_square, coef_linear, coef_constant, input ready);
  modport sink   (input valid, coef_square, coef_linear, coef_constant, output ready);
endinterface

interface qrs_out_if import qrs_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [1:0]         root_count;
  logic [FIELD_W-1:0] root_first;
  logic [FIELD_W-1:0] root_second;
  logic [1:0]         status;
  modport source (output valid, root_count, root_first, root_second, status, input ready);
  modport sink   (input valid, root_count, root_first, root_second, status, output ready);
endinterface

/* design/quadratic_real_root_solver.sv */
// Quadratic real root solver top level: front end, square root, dividers
// and result register. Depends on qrs_pkg, qrs_if, qrs_sqrt and qrs_div.
//
// Takes a, b, c of a*x^2+b*x+c in signed Q16.16 and returns one result per
// transaction: root count, the +sqrt root (or single root), the -sqrt root
// and a status (ok, leading coefficient zero, root saturated). A new
// transaction is accepted every cycle while the pipeline advances; the
// 33-stage square root and the 50-stage dividers work one bit per stage.
// The whole pipeline advances whenever the result register is empty or
// being taken, so back-pressure holds every stage in place.
module quadratic_real_root_solver import qrs_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  qrs_in_if.sink    in_ch,
  qrs_out_if.source out_ch
);

  typedef struct packed {
    logic               sat;
    logic [FIELD_W-1:0] val;
  } sat_res_t;

  function automatic sat_res_t sat_root(logic [DIVD_W-1:0] q, logic neg);
    sat_res_t res;
    res.sat = 1'b0;
    if (!neg || q == '0) begin
      if (q > DIVD_W'(32'h7FFF_FFFF)) begin
        res.sat = 1'b1;
        res.val = 32'h7FFF_FFFF;
      end else begin
        res.val = q[FIELD_W-1:0];
      end
    end else if (q > DIVD_W'(32'h8000_0000)) begin
      res.sat = 1'b1;
      res.val = 32'h8000_0000;
    end else begin
      res.val = FIELD_W'(~q + DIVD_W'(1));
    end
    return res;
  endfunction

  logic en;
  logic out_v_r;
  assign en          = !out_v_r || out_ch.ready;
  assign in_ch.ready = en;

  // stage 1: magnitudes and signs
  logic             v1_r, an1_r, bn1_r, cn1_r;
  logic [MAG_W-1:0] ua1_r, ub1_r, uc1_r;
  logic             an_nxt, bn_nxt, cn_nxt;
  assign an_nxt = in_ch.coef_square[FIELD_W-1];
  assign bn_nxt = in_ch.coef_linear[FIELD_W-1];
  assign cn_nxt = in_ch.coef_constant[FIELD_W-1];

  always_ff @(posedge clk) begin
    if (en) begin
      an1_r <= an_nxt;
      bn1_r <= bn_nxt;
      cn1_r <= cn_nxt;
      ua1_r <= an_nxt ? (~in_ch.coef_square + 1'b1) : in_ch.coef_square;
      ub1_r <= bn_nxt ? (~in_ch.coef_linear + 1'b1) : in_ch.coef_linear;
      uc1_r <= cn_nxt ? (~in_ch.coef_constant + 1'b1) : in_ch.coef_constant;
    end
  end

  // stage 2: b*b and a*c
  logic              v2_r, an2_r, nb2_r, opp2_r, az2_r;
  logic [PROD_W-1:0] bb2_r, ac2_r;
  logic [MAG_W-1:0]  ua2_r, ub2_r;

  always_ff @(posedge clk) begin
    if (en) begin
      bb2_r  <= PROD_W'(ub1_r) * PROD_W'(ub1_r);
      ac2_r  <= PROD_W'(ua1_r) * PROD_W'(uc1_r);
      an2_r  <= an1_r;
      nb2_r  <= !bn1_r && ub1_r != '0;
      opp2_r <= an1_r != cn1_r;
      az2_r  <= ua1_r == '0;
      ua2_r  <= ua1_r;
      ub2_r  <= ub1_r;
    end
  end

  // stage 3: discriminant b*b - 4ac, signed
  logic              v3_r;
  logic [DISC_W-1:0] d3_r;
  sq_side_t          side3_r;
  logic [DISC_W:0]   disc;
  logic [DISC_W:0]   four_ac;
  assign four_ac = {1'b0, ac2_r, 2'b00};
  assign disc = opp2_r ? ({3'b000, bb2_r} + four_ac) : ({3'b000, bb2_r} - four_ac);

  always_ff @(posedge clk) begin
    if (en) begin
      d3_r           <= disc[DISC_W-1:0];
      side3_r.a_zero <= az2_r;
      side3_r.d_neg  <= disc[DISC_W];
      side3_r.d_zero <= disc == '0;
      side3_r.an     <= an2_r;
      side3_r.nb     <= nb2_r;
      side3_r.ub     <= ub2_r;
      side3_r.den    <= {ua2_r, 1'b0};
    end
  end

  // valid bits of the front end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_ch.valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  // square root
  logic              sq_v;
  logic [ROOT_W-1:0] sq_root;
  sq_side_t          sq_side;

  qrs_sqrt u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (v3_r),
    .in_value  (d3_r),
    .in_side   (side3_r),
    .out_valid (sq_v),
    .out_root  (sq_root),
    .out_side  (sq_side)
  );

  // stage 4: numerators -b +/- sqrt(D) and their signs
  logic [NUM_W-1:0] s_ext, ub_ext, m1, m2;
  logic             mn1, mn2;
  logic [1:0]       cnt;
  assign s_ext  = NUM_W'(sq_root);
  assign ub_ext = NUM_W'(sq_side.ub);

  always_comb begin
    if (sq_side.a_zero || sq_side.d_neg) begin
      cnt = CNT_NONE;
    end else if (sq_side.d_zero) begin
      cnt = CNT_SINGLE;
    end else begin
      cnt = CNT_PAIR;
    end
    if (cnt == CNT_SINGLE) begin
      m1 = ub_ext; mn1 = sq_side.nb;
    end else if (!sq_side.nb) begin
      m1 = ub_ext + s_ext; mn1 = 1'b0;
    end else if (s_ext >= ub_ext) begin
      m1 = s_ext - ub_ext; mn1 = 1'b0;
    end else begin
      m1 = ub_ext - s_ext; mn1 = 1'b1;
    end
    if (sq_side.nb) begin
      m2 = ub_ext + s_ext; mn2 = 1'b1;
    end else if (ub_ext >= s_ext) begin
      m2 = ub_ext - s_ext; mn2 = 1'b0;
    end else begin
      m2 = s_ext - ub_ext; mn2 = 1'b1;
    end
  end

  logic              v4_r;
  logic [DIVD_W-1:0] n1_r, n2_r;
  logic [DEN_W-1:0]  den4_r;
  post_t             post4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (en) begin
      v4_r <= sq_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n1_r              <= {m1, {FRAC_BITS{1'b0}}};
      n2_r              <= {m2, {FRAC_BITS{1'b0}}};
      den4_r            <= sq_side.den;
      post4_r.count     <= cnt;
      post4_r.lead_zero <= sq_side.a_zero;
      post4_r.neg1      <= mn1 != sq_side.an;
      post4_r.neg2      <= mn2 != sq_side.an;
    end
  end

  // two dividers in lockstep
  logic              dv1_v, dv2_v;
  logic [DIVD_W-1:0] q1, q2;

  qrs_div u_div_first (
    .clk (clk), .rst_n (rst_n), .en (en),
    .in_valid (v4_r), .in_num (n1_r), .in_den (den4_r),
    .out_valid (dv1_v), .out_quo (q1)
  );

  qrs_div u_div_second (
    .clk (clk), .rst_n (rst_n), .en (en),
    .in_valid (v4_r), .in_num (n2_r), .in_den (den4_r),
    .out_valid (dv2_v), .out_quo (q2)
  );

  // sideband shift line matching the divider latency
  post_t post_r [DV_STAGES];
  always_ff @(posedge clk) begin
    if (en) begin
      post_r[0] <= post4_r;
      for (int i = 1; i < DV_STAGES; i++) begin
        post_r[i] <= post_r[i-1];
      end
    end
  end

  // result register
  post_t              pe;
  sat_res_t           rs1, rs2;
  logic [1:0]         cnt_r, stat_r;
  logic [FIELD_W-1:0] r1_r, r2_r;
  logic [FIELD_W-1:0] r1_nxt, r2_nxt;
  logic [1:0]         stat_nxt;
  assign pe  = post_r[DV_STAGES-1];
  assign rs1 = sat_root(q1, pe.neg1);
  assign rs2 = sat_root(q2, pe.neg2);

  always_comb begin
    r1_nxt   = '0;
    r2_nxt   = '0;
    stat_nxt = pe.lead_zero ? STAT_LEAD_ZERO : STAT_OK;
    if (pe.count == CNT_SINGLE) begin
      r1_nxt = rs1.val;
      if (rs1.sat) stat_nxt = STAT_SAT;
    end else if (pe.count == CNT_PAIR) begin
      r1_nxt = rs1.val;
      r2_nxt = rs2.val;
      if (rs1.sat || rs2.sat) stat_nxt = STAT_SAT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (en) begin
      out_v_r <= dv1_v && dv2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cnt_r  <= pe.count;
      r1_r   <= r1_nxt;
      r2_r   <= r2_nxt;
      stat_r <= stat_nxt;
    end
  end

  assign out_ch.valid       = out_v_r;
  assign out_ch.root_count  = cnt_r;
  assign out_ch.root_first  = r1_r;
  assign out_ch.root_second = r2_r;
  assign out_ch.status      = stat_r;

  // checks
  a_lead_zero_no_roots: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && stat_r == STAT_LEAD_ZERO |-> cnt_r == CNT_NONE && r1_r == '0 && r2_r == '0)
    else $error("leading coefficient zero reported roots");

  a_single_second_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && cnt_r == CNT_SINGLE |-> r2_r == '0)
    else $error("single root with non-zero second root");

  a_dividers_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
    dv1_v == dv2_v)
    else $error("dividers out of step");

endmodule

/* design/qrs_sqrt.sv */
// Pipelined integer square root, one result bit per stage, with sideband.
// Depends on qrs_pkg.
module qrs_sqrt import qrs_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  logic [DISC_W-1:0] in_value,
  input  sq_side_t          in_side,
  output logic              out_valid,
  output logic [ROOT_W-1:0] out_root,
  output sq_side_t          out_side
);

  logic [DISC_W-1:0] e_r [SQ_STAGES];
  logic [ROOT_W-1:0] r_r [SQ_STAGES];
  sq_side_t          s_r [SQ_STAGES];
  logic [SQ_STAGES-1:0] v_r;

  genvar k;
  generate
    for (k = 0; k < SQ_STAGES; k++) begin : g_st
      localparam int BIT = SQ_STAGES - 1 - k;
      logic [DISC_W-1:0] e_in, inc;
      logic [ROOT_W-1:0] r_in;
      logic              v_in;
      sq_side_t          s_in;
      if (k == 0) begin : g_first
        assign e_in = in_value;
        assign r_in = '0;
        assign v_in = in_valid;
        assign s_in = in_side;
      end else begin : g_rest
        assign e_in = e_r[k-1];
        assign r_in = r_r[k-1];
        assign v_in = v_r[k-1];
        assign s_in = s_r[k-1];
      end
      // (r + 2^i)^2 - r^2 = r*2^(i+1) + 2^(2i)
      assign inc = ({{(DISC_W-ROOT_W){1'b0}}, r_in} << (BIT + 1))
                 | (DISC_W'(1) << (2 * BIT));

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          v_r[k] <= 1'b0;
        end else if (en) begin
          v_r[k] <= v_in;
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          s_r[k] <= s_in;
          if (e_in >= inc) begin
            e_r[k] <= e_in - inc;
            r_r[k] <= r_in | (ROOT_W'(1) << BIT);
          end else begin
            e_r[k] <= e_in;
            r_r[k] <= r_in;
          end
        end
      end
    end
  endgenerate

  assign out_valid = v_r[SQ_STAGES-1];
  assign out_root  = r_r[SQ_STAGES-1];
  assign out_side  = s_r[SQ_STAGES-1];

endmodule

/* design/qrs_div.sv */
// Pipelined restoring unsigned divider, one quotient bit per stage.
// Depends on qrs_pkg.
module qrs_div import qrs_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  logic [DIVD_W-1:0] in_num,
  input  logic [DEN_W-1:0]  in_den,
  output logic              out_valid,
  output logic [DIVD_W-1:0] out_quo
);

  logic [DEN_W-1:0]  rem_r [DV_STAGES];
  logic [DIVD_W-1:0] num_r [DV_STAGES];
  logic [DIVD_W-1:0] quo_r [DV_STAGES];
  logic [DEN_W-1:0]  den_r [DV_STAGES];
  logic [DV_STAGES-1:0] v_r;

  genvar k;
  generate
    for (k = 0; k < DV_STAGES; k++) begin : g_st
      logic [DEN_W-1:0]  rem_in, den_in;
      logic [DIVD_W-1:0] num_in, quo_in;
      logic              v_in;
      logic [DEN_W:0]    trial;
      if (k == 0) begin : g_first
        assign rem_in = '0;
        assign num_in = in_num;
        assign quo_in = '0;
        assign den_in = in_den;
        assign v_in   = in_valid;
      end else begin : g_rest
        assign rem_in = rem_r[k-1];
        assign num_in = num_r[k-1];
        assign quo_in = quo_r[k-1];
        assign den_in = den_r[k-1];
        assign v_in   = v_r[k-1];
      end
      assign trial = {rem_in, num_in[DIVD_W-1]};

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          v_r[k] <= 1'b0;
        end else if (en) begin
          v_r[k] <= v_in;
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          den_r[k] <= den_in;
          num_r[k] <= {num_in[DIVD_W-2:0], 1'b0};
          if (trial >= {1'b0, den_in}) begin
            rem_r[k] <= DEN_W'(trial - {1'b0, den_in});
            quo_r[k] <= {quo_in[DIVD_W-2:0], 1'b1};
          end else begin
            rem_r[k] <= trial[DEN_W-1:0];
            quo_r[k] <= {quo_in[DIVD_W-2:0], 1'b0};
          end
        end
      end
    end
  endgenerate

  assign out_valid = v_r[DV_STAGES-1];
  assign out_quo   = quo_r[DV_STAGES-1];

endmodule
